// ===== src/tdrr_pkg.sv =====
// Shared types, widths and codes of the tile depth range reject block.
package tdrr_pkg;

   // Tile edge in pixels; the local store holds one word per pixel of the tile.
   localparam int TILE_SIZE = 64;
   localparam int MEM_DEPTH = TILE_SIZE * TILE_SIZE;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int IDX_W     = $clog2(TILE_SIZE);
   localparam int SPAN_W    = $clog2(TILE_SIZE + 1);

   localparam int DEPTH_W    = 32;
   localparam int LOCAL_W    = 6;
   localparam int ORIGIN_W   = 14;
   localparam int FRAME_W    = 15;
   localparam int QUAD_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int PROD_W     = DEPTH_W + IDX_W + 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TEST  = 1'b1;

   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

   typedef enum logic [2:0] {
      CMP_NEVER         = 3'd0,
      CMP_LESS          = 3'd1,
      CMP_LESS_EQUAL    = 3'd2,
      CMP_GREATER       = 3'd3,
      CMP_GREATER_EQUAL = 3'd4,
      CMP_EQUAL         = 3'd5,
      CMP_NOT_EQUAL     = 3'd6,
      CMP_ALWAYS        = 3'd7
   } cmp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_REJECT_ENABLE       = 3'd0,
      REG_DEPTH_TEST_ENABLE   = 3'd1,
      REG_DEPTH_COMPARE       = 3'd2,
      REG_SHADER_WRITES_DEPTH = 3'd3,
      REG_FRAME_WIDTH         = 3'd4,
      REG_FRAME_HEIGHT        = 3'd5,
      REG_MIN_QUADS           = 3'd6
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ADD_10,
      ST_ADD_01,
      ST_ADD_11,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic signed [DEPTH_W-1:0] lo;
      logic signed [DEPTH_W-1:0] hi;
   } range_type;

endpackage

// ===== src/tdrr_if.sv =====
// Valid/ready channel interfaces of the tile depth range reject block.
interface tdrr_req_if;
   import tdrr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [LOCAL_W-1:0]         local_x;
   logic [LOCAL_W-1:0]         local_y;
   logic signed [DEPTH_W-1:0]  stored_depth;
   logic [ORIGIN_W-1:0]        tile_x;
   logic [ORIGIN_W-1:0]        tile_y;
   logic signed [DEPTH_W-1:0]  plane_depth;
   logic signed [DEPTH_W-1:0]  slope_x;
   logic signed [DEPTH_W-1:0]  slope_y;
   logic [QUAD_W-1:0]          quad_count;

   modport source (output valid, cmd, local_x, local_y, stored_depth, tile_x, tile_y,
                   plane_depth, slope_x, slope_y, quad_count, input ready);
   modport sink   (input valid, cmd, local_x, local_y, stored_depth, tile_x, tile_y,
                   plane_depth, slope_x, slope_y, quad_count, output ready);
   modport mon    (input valid, ready, cmd, local_x, local_y, stored_depth, tile_x, tile_y,
                   plane_depth, slope_x, slope_y, quad_count);
endinterface

interface tdrr_rsp_if;
   logic valid;
   logic ready;
   logic tested;
   logic rejected;

   modport source (output valid, tested, rejected, input ready);
   modport sink   (input valid, tested, rejected, output ready);
   modport mon    (input valid, ready, tested, rejected);
endinterface

interface tdrr_csr_if;
   import tdrr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
   modport mon    (input valid, ready, index, data);
endinterface

// ===== src/tdrr_arith_unit.sv =====
// Shared saturating multiplier, saturating adder and min/max range update.
module tdrr_arith_unit (
   input  logic signed [tdrr_pkg::DEPTH_W-1:0] mul_a,
   input  logic [tdrr_pkg::IDX_W-1:0]          mul_b,
   output logic signed [tdrr_pkg::DEPTH_W-1:0] mul_sat,
   input  logic signed [tdrr_pkg::DEPTH_W-1:0] add_a,
   input  logic signed [tdrr_pkg::DEPTH_W-1:0] add_b,
   output logic signed [tdrr_pkg::DEPTH_W-1:0] add_sat,
   input  tdrr_pkg::range_type                 rng_in,
   input  logic signed [tdrr_pkg::DEPTH_W-1:0] rng_z,
   output tdrr_pkg::range_type                 rng_out
);
   import tdrr_pkg::*;

   logic signed [PROD_W-1:0]       prod;
   logic [PROD_W-DEPTH_W:0]        prod_top;
   logic [DEPTH_W:0]               sum;

   // Slope times span minus one; the product fits 32 bits when its top bits agree.
   always_comb begin
      prod     = mul_a * $signed({1'b0, mul_b});
      prod_top = prod[PROD_W-1:DEPTH_W-1];
      if ((&prod_top) || !(|prod_top)) begin
         mul_sat = prod[DEPTH_W-1:0];
      end else if (prod[PROD_W-1]) begin
         mul_sat = DEPTH_MIN;
      end else begin
         mul_sat = DEPTH_MAX;
      end
   end

   always_comb begin
      sum = {add_a[DEPTH_W-1], add_a} + {add_b[DEPTH_W-1], add_b};
      if (sum[DEPTH_W] == sum[DEPTH_W-1]) begin
         add_sat = sum[DEPTH_W-1:0];
      end else if (sum[DEPTH_W]) begin
         add_sat = DEPTH_MIN;
      end else begin
         add_sat = DEPTH_MAX;
      end
   end

   always_comb begin
      rng_out.lo = (rng_z < rng_in.lo) ? rng_z : rng_in.lo;
      rng_out.hi = (rng_z > rng_in.hi) ? rng_z : rng_in.hi;
   end

endmodule

// ===== src/tile_depth_range_reject_core.sv =====
// Top level of the tile depth range reject block: sequencer, tile store and range cache.
//
// The block keeps one tile of Q16.16 depth words and a cached min/max of it. A write word
// stores one depth value and clears the cache; it is answered in the cycle after acceptance
// with tested and rejected both low. A test word is first put through the gating checks
// (block disabled, too few quads, depth test off, compare always or never, shader writes
// depth, tile origin outside the framebuffer); a test settled there is also answered in
// the cycle after acceptance. A test that goes through works its four tile corners on one
// shared saturating multiplier and adder, two products and then three sums. When the cache
// is not valid the clipped span of the tile is then read from the store through its read
// port one word per cycle. The store is not cleared after reset: a scan must only cover
// entries that have been written. One item is worked on at a time, and the input is ready
// only when the sequencer is idle and the response register is empty or being emptied. The
// configuration port is always ready outside reset and must only be written while the block
// is idle.
module tile_depth_range_reject_core (
   input  logic        clock,
   input  logic        reset,
   tdrr_req_if.sink    req_chan,
   tdrr_rsp_if.source  rsp_chan,
   tdrr_csr_if.sink    csr_chan
);
   import tdrr_pkg::*;

   // Configuration registers.
   logic                reject_enable_ff, reject_enable_in;
   logic                depth_test_enable_ff, depth_test_enable_in;
   cmp_type             depth_compare_ff, depth_compare_in;
   logic                shader_writes_depth_ff, shader_writes_depth_in;
   logic [FRAME_W-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0]  frame_height_ff, frame_height_in;
   logic [QUAD_W-1:0]   min_quads_ff, min_quads_in;

   // Sequencer and control state.
   state_type           state_ff, state_in;
   logic                cache_valid_ff, cache_valid_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                scan_first_ff, scan_first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_tested_ff, rsp_tested_in;
   logic                rsp_rejected_ff, rsp_rejected_in;

   // Payload registers of the test in flight.
   logic signed [DEPTH_W-1:0] plane_ff, plane_in;
   logic signed [DEPTH_W-1:0] slope_x_ff, slope_x_in;
   logic signed [DEPTH_W-1:0] slope_y_ff, slope_y_in;
   logic [SPAN_W-1:0]         span_w_ff, span_w_in;
   logic [SPAN_W-1:0]         span_h_ff, span_h_in;
   logic signed [DEPTH_W-1:0] prod_x_ff, prod_x_in;
   logic signed [DEPTH_W-1:0] prod_y_ff, prod_y_in;
   logic signed [DEPTH_W-1:0] d10_ff, d10_in;
   range_type                 prange_ff, prange_in;
   range_type                 crange_ff, crange_in;
   logic [IDX_W-1:0]          x_cnt_ff, x_cnt_in;
   logic [IDX_W-1:0]          y_cnt_ff, y_cnt_in;
   logic [ADDR_W-1:0]         row_base_ff, row_base_in;
   logic signed [DEPTH_W-1:0] rd_data_ff;

   // The tile store itself.
   logic signed [DEPTH_W-1:0] tile_mem [MEM_DEPTH];

   // Handshakes and gating.
   logic                req_accept, csr_accept, slot_free;
   logic                write_cmd, write_in_tile;
   logic [ADDR_W-1:0]   wr_addr;
   logic                skip_test, go_test;
   logic                imm_tested, imm_rejected;
   logic [FRAME_W-1:0]  fw_diff, fh_diff;

   // Sequencer outputs.
   logic                idle, scan_issue, decide;
   logic                x_last, y_last, scan_last;
   logic [ADDR_W-1:0]   scan_addr;
   logic                reject_now;

   // Shared unit connections.
   logic signed [DEPTH_W-1:0] mul_a, mul_sat, add_a, add_b, add_sat, rng_z;
   logic [IDX_W-1:0]          mul_b;
   range_type                 rng_in, rng_out;

   tdrr_arith_unit u_arith (
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_sat (mul_sat),
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sat (add_sat),
      .rng_in  (rng_in),
      .rng_z   (rng_z),
      .rng_out (rng_out)
   );

   // Handshakes. A new word is only taken when the response register can receive its answer.
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = idle && slot_free && !reset;
   assign csr_chan.ready = !reset;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.tested   = rsp_tested_ff;
   assign rsp_chan.rejected = rsp_rejected_ff;

   // A write outside the tile (possible only for tiles narrower than the local fields) is dropped.
   assign write_cmd     = (req_chan.cmd == CMD_WRITE);
   assign write_in_tile = ({1'b0, req_chan.local_x} < (LOCAL_W+1)'(TILE_SIZE)) &&
                          ({1'b0, req_chan.local_y} < (LOCAL_W+1)'(TILE_SIZE));
   assign wr_addr       = ADDR_W'(int'(req_chan.local_y) * TILE_SIZE + int'(req_chan.local_x));

   // Gating checks, in the order of their priority. Only a test that clears all of them
   // goes on to the corner and range work.
   always_comb begin
      skip_test    = !reject_enable_ff || (req_chan.quad_count < min_quads_ff) ||
                     !depth_test_enable_ff || (depth_compare_ff == CMP_ALWAYS);
      go_test      = 1'b0;
      imm_tested   = 1'b0;
      imm_rejected = 1'b0;
      if (write_cmd || skip_test) begin
         imm_tested = 1'b0;
      end else if (depth_compare_ff == CMP_NEVER) begin
         imm_tested   = 1'b1;
         imm_rejected = 1'b1;
      end else if (shader_writes_depth_ff) begin
         imm_tested = 1'b0;
      end else if (({1'b0, req_chan.tile_x} >= frame_width_ff) ||
                   ({1'b0, req_chan.tile_y} >= frame_height_ff)) begin
         imm_tested   = 1'b1;
         imm_rejected = 1'b1;
      end else begin
         go_test = 1'b1;
      end
   end

   // Clipped span of the tile; only used when the origin lies inside the frame.
   assign fw_diff = frame_width_ff - {1'b0, req_chan.tile_x};
   assign fh_diff = frame_height_ff - {1'b0, req_chan.tile_y};

   // Scan position.
   assign x_last    = (SPAN_W'(x_cnt_ff) == span_w_ff - SPAN_W'(1));
   assign y_last    = (SPAN_W'(y_cnt_ff) == span_h_ff - SPAN_W'(1));
   assign scan_last = x_last && y_last;
   assign scan_addr = row_base_ff + ADDR_W'(x_cnt_ff);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && go_test) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_ADD_10;
         ST_ADD_10: state_in = ST_ADD_01;
         ST_ADD_01: state_in = ST_ADD_11;
         ST_ADD_11: begin
            state_in = cache_valid_ff ? ST_DECIDE : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: which operands feed the shared unit.
   always_comb begin
      idle       = (state_ff == ST_IDLE);
      scan_issue = (state_ff == ST_SCAN);
      decide     = (state_ff == ST_DECIDE);
      mul_a      = slope_x_ff;
      mul_b      = IDX_W'(span_w_ff - SPAN_W'(1));
      add_a      = plane_ff;
      add_b      = prod_x_ff;
      case (state_ff)
         ST_MUL_Y: begin
            mul_a = slope_y_ff;
            mul_b = IDX_W'(span_h_ff - SPAN_W'(1));
         end
         ST_ADD_01: begin
            add_b = prod_y_ff;
         end
         ST_ADD_11: begin
            add_a = d10_ff;
            add_b = prod_y_ff;
         end
         default: begin
            add_b = prod_x_ff;
         end
      endcase
   end

   // The range update serves the corners first and the scanned words afterwards.
   always_comb begin
      if (rd_valid_ff) begin
         rng_z = rd_data_ff;
         if (scan_first_ff) begin
            rng_in.lo = rd_data_ff;
            rng_in.hi = rd_data_ff;
         end else begin
            rng_in = crange_ff;
         end
      end else begin
         rng_z  = add_sat;
         rng_in = prange_ff;
      end
   end

   // Range comparison for the selected depth function.
   always_comb begin
      case (depth_compare_ff)
         CMP_LESS:          reject_now = (prange_ff.lo >= crange_ff.hi);
         CMP_LESS_EQUAL:    reject_now = (prange_ff.lo > crange_ff.hi);
         CMP_GREATER:       reject_now = (prange_ff.hi <= crange_ff.lo);
         CMP_GREATER_EQUAL: reject_now = (prange_ff.hi < crange_ff.lo);
         CMP_EQUAL:         reject_now = (prange_ff.hi < crange_ff.lo) ||
                                         (prange_ff.lo > crange_ff.hi);
         CMP_NOT_EQUAL:     reject_now = (prange_ff.lo == prange_ff.hi) &&
                                         (crange_ff.lo == crange_ff.hi) &&
                                         (prange_ff.lo == crange_ff.lo);
         default:           reject_now = 1'b0;
      endcase
   end

   // Configuration writes; each register keeps only its own width of the data.
   always_comb begin
      reject_enable_in       = reject_enable_ff;
      depth_test_enable_in   = depth_test_enable_ff;
      depth_compare_in       = depth_compare_ff;
      shader_writes_depth_in = shader_writes_depth_ff;
      frame_width_in         = frame_width_ff;
      frame_height_in        = frame_height_ff;
      min_quads_in           = min_quads_ff;
      if (csr_accept) begin
         case (csr_reg_type'(csr_chan.index))
            REG_REJECT_ENABLE:       reject_enable_in       = csr_chan.data[0];
            REG_DEPTH_TEST_ENABLE:   depth_test_enable_in   = csr_chan.data[0];
            REG_DEPTH_COMPARE:       depth_compare_in       = cmp_type'(csr_chan.data[2:0]);
            REG_SHADER_WRITES_DEPTH: shader_writes_depth_in = csr_chan.data[0];
            REG_FRAME_WIDTH:         frame_width_in         = csr_chan.data[FRAME_W-1:0];
            REG_FRAME_HEIGHT:        frame_height_in        = csr_chan.data[FRAME_W-1:0];
            REG_MIN_QUADS:           min_quads_in           = csr_chan.data[QUAD_W-1:0];
            default:                 min_quads_in           = min_quads_ff;
         endcase
      end
   end

   // Control next values.
   always_comb begin
      cache_valid_in  = cache_valid_ff;
      rd_valid_in     = scan_issue;
      scan_first_in   = scan_first_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_tested_in   = rsp_tested_ff;
      rsp_rejected_in = rsp_rejected_ff;

      if (req_accept && write_cmd && write_in_tile) begin
         cache_valid_in = 1'b0;
      end
      if (state_ff == ST_DRAIN) begin
         cache_valid_in = 1'b1;
      end
      if (state_ff == ST_ADD_11) begin
         scan_first_in = 1'b1;
      end else if (rd_valid_ff) begin
         scan_first_in = 1'b0;
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && !go_test) begin
         rsp_valid_in    = 1'b1;
         rsp_tested_in   = imm_tested;
         rsp_rejected_in = imm_rejected;
      end else if (decide && slot_free) begin
         rsp_valid_in    = 1'b1;
         rsp_tested_in   = 1'b1;
         rsp_rejected_in = reject_now;
      end
   end

   // Payload next values.
   always_comb begin
      plane_in    = plane_ff;
      slope_x_in  = slope_x_ff;
      slope_y_in  = slope_y_ff;
      span_w_in   = span_w_ff;
      span_h_in   = span_h_ff;
      prod_x_in   = prod_x_ff;
      prod_y_in   = prod_y_ff;
      d10_in      = d10_ff;
      prange_in   = prange_ff;
      crange_in   = crange_ff;
      x_cnt_in    = x_cnt_ff;
      y_cnt_in    = y_cnt_ff;
      row_base_in = row_base_ff;

      if (req_accept && go_test) begin
         plane_in     = req_chan.plane_depth;
         slope_x_in   = req_chan.slope_x;
         slope_y_in   = req_chan.slope_y;
         span_w_in    = (fw_diff > FRAME_W'(TILE_SIZE)) ? SPAN_W'(TILE_SIZE) : SPAN_W'(fw_diff);
         span_h_in    = (fh_diff > FRAME_W'(TILE_SIZE)) ? SPAN_W'(TILE_SIZE) : SPAN_W'(fh_diff);
         prange_in.lo = req_chan.plane_depth;
         prange_in.hi = req_chan.plane_depth;
         x_cnt_in     = '0;
         y_cnt_in     = '0;
         row_base_in  = '0;
      end

      case (state_ff)
         ST_MUL_X:  prod_x_in = mul_sat;
         ST_MUL_Y:  prod_y_in = mul_sat;
         ST_ADD_10: begin
            d10_in    = add_sat;
            prange_in = rng_out;
         end
         ST_ADD_01: prange_in = rng_out;
         ST_ADD_11: prange_in = rng_out;
         ST_SCAN: begin
            if (x_last) begin
               x_cnt_in    = '0;
               y_cnt_in    = y_cnt_ff + IDX_W'(1);
               row_base_in = row_base_ff + ADDR_W'(TILE_SIZE);
            end else begin
               x_cnt_in = x_cnt_ff + IDX_W'(1);
            end
         end
         default:   d10_in = d10_ff;
      endcase

      if (rd_valid_ff) begin
         crange_in = rng_out;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reject_enable_ff       <= 1'b0;
         depth_test_enable_ff   <= 1'b0;
         depth_compare_ff       <= CMP_LESS;
         shader_writes_depth_ff <= 1'b0;
         frame_width_ff         <= '0;
         frame_height_ff        <= '0;
         min_quads_ff           <= QUAD_W'(1024);
         state_ff               <= ST_IDLE;
         cache_valid_ff         <= 1'b0;
         rd_valid_ff            <= 1'b0;
         scan_first_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         rsp_tested_ff          <= 1'b0;
         rsp_rejected_ff        <= 1'b0;
         crange_ff              <= '0;
      end else begin
         reject_enable_ff       <= reject_enable_in;
         depth_test_enable_ff   <= depth_test_enable_in;
         depth_compare_ff       <= depth_compare_in;
         shader_writes_depth_ff <= shader_writes_depth_in;
         frame_width_ff         <= frame_width_in;
         frame_height_ff        <= frame_height_in;
         min_quads_ff           <= min_quads_in;
         state_ff               <= state_in;
         cache_valid_ff         <= cache_valid_in;
         rd_valid_ff            <= rd_valid_in;
         scan_first_ff          <= scan_first_in;
         rsp_valid_ff           <= rsp_valid_in;
         rsp_tested_ff          <= rsp_tested_in;
         rsp_rejected_ff        <= rsp_rejected_in;
         crange_ff              <= crange_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      plane_ff    <= plane_in;
      slope_x_ff  <= slope_x_in;
      slope_y_ff  <= slope_y_in;
      span_w_ff   <= span_w_in;
      span_h_ff   <= span_h_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      d10_ff      <= d10_in;
      prange_ff   <= prange_in;
      x_cnt_ff    <= x_cnt_in;
      y_cnt_ff    <= y_cnt_in;
      row_base_ff <= row_base_in;
   end

   // Tile store: one write port for depth words, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (req_accept && write_cmd && write_in_tile) begin
         tile_mem[wr_addr] <= req_chan.stored_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_data_ff <= tile_mem[scan_addr];
      end
   end

endmodule

// ===== src/tdrr_checker.sv =====
// Port-level assertions for the tile depth range reject block, bound to its top level.
module tdrr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_cmd,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_tested,
   input logic rsp_rejected,
   input logic csr_valid,
   input logic csr_ready
);
   import tdrr_pkg::*;

   logic req_accept;
   logic csr_accept;

   assign req_accept = req_valid && req_ready;
   assign csr_accept = csr_valid && csr_ready;

   // A response word waiting for the sink holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_tested) && $stable(rsp_rejected))
      else $error("response word changed while stalled");

   // A depth write is answered at once, as not tested.
   a_write_reply: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_cmd == CMD_WRITE) |=>
         rsp_valid && !rsp_tested && !rsp_rejected)
      else $error("depth write not answered as untested in the next cycle");

   // Only a test that was carried out can reject the tile.
   a_reject_tested: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_tested)
      else $error("reject reported without a test");

   // After an accepted word the block is either answering it or busy with it.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid || !req_ready)
      else $error("new word taken while the previous one has no answer");

   // Configuration writes are taken whenever offered outside reset.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_accept)
      else $error("configuration write refused");

endmodule

bind tile_depth_range_reject_core tdrr_checker u_tdrr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_cmd      (req_chan.cmd),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_tested   (rsp_chan.tested),
   .rsp_rejected (rsp_chan.rejected),
   .csr_valid    (csr_chan.valid),
   .csr_ready    (csr_chan.ready)
);
